### hw/rtl/cartridge_bank_controller_unit_macros.svh
// assertion macros for the cartridge bank controller
`ifndef CARTRIDGE_BANK_CONTROLLER_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbc assertion failed");
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbc assertion failed");
`else
`define CBC_ASSERT_SAME(label, clk, rst, ante, cons)
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/cbc_pkg.sv
// shared types and constants of the cartridge bank controller
`timescale 1ns / 1ps
package cbc_pkg;

   localparam int ROM_BANK_BITS = 14;
   localparam int RAM_BANK_BITS = 13;
   localparam int MEM_ADDR_W    = 23;
   localparam int ROM_BANK_W    = 9;
   localparam int RAM_BANK_W    = 4;
   localparam int KIND_W        = 2;

   localparam logic [KIND_W-1:0] KIND_MBC1   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MBC3   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MBC5   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic [7:0] MBC3_RAM_BANK_MAX = 8'd7;

   typedef enum logic [1:0] {
      FUNC_ROM_READ  = 2'd0,
      FUNC_REG_WRITE = 2'd1,
      FUNC_RAM_READ  = 2'd2,
      FUNC_RAM_WRITE = 2'd3
   } func_type;

   // register selected by address bits 14..12 of a rom-area write
   typedef enum logic [2:0] {
      TGT_RAM_ENABLE,
      TGT_ROM_BANK_LO,
      TGT_ROM_BANK_HI,
      TGT_RAM_BANK,
      TGT_MODE
   } target_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [14:0] bus_address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [MEM_ADDR_W-1:0] memory_address;
      logic                  memory_strobe;
      logic                  memory_write;
      logic                  ram_select;
      logic                  open_bus;
      logic [7:0]            store_data;
   } rsp_type;

   typedef struct packed {
      func_type                 op;
      target_type               target;
      logic                     rom_upper;
      logic [ROM_BANK_BITS-1:0] offset;
      logic [7:0]               data;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### hw/rtl/cbc_front.sv
// front end: accepts bus words and classifies them
`timescale 1ns / 1ps
module cbc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cbc_pkg::req_type          req_word,
   input  cbc_pkg::queue_status_type queue_status,
   output logic                      push,
   output cbc_pkg::item_type         push_item
);

   logic              front_valid_ff, front_valid_in;
   cbc_pkg::item_type front_item_ff, front_item_in;
   cbc_pkg::target_type target;

   always_comb begin
      unique case (req_word.bus_address[14:12])
         3'd0, 3'd1: target = cbc_pkg::TGT_RAM_ENABLE;
         3'd2:       target = cbc_pkg::TGT_ROM_BANK_LO;
         3'd3:       target = cbc_pkg::TGT_ROM_BANK_HI;
         3'd4, 3'd5: target = cbc_pkg::TGT_RAM_BANK;
         default:    target = cbc_pkg::TGT_MODE;
      endcase
   end

   assign push      = front_valid_ff && !queue_status.full;
   assign push_item = front_item_ff;
   assign req_stall = front_valid_ff && queue_status.full;

   always_comb begin
      front_valid_in = front_valid_ff;
      front_item_in  = front_item_ff;
      if (!req_stall) begin
         front_valid_in          = req_valid;
         front_item_in.op        = cbc_pkg::func_type'(req_word.func);
         front_item_in.target    = target;
         front_item_in.rom_upper = req_word.bus_address[14];
         front_item_in.offset    = req_word.bus_address[cbc_pkg::ROM_BANK_BITS-1:0];
         front_item_in.data      = req_word.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_item_ff <= front_item_in;
   end

endmodule

### hw/rtl/cbc_queue.sv
// short queue between front end and back end
`timescale 1ns / 1ps
module cbc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cbc_pkg::item_type         push_item,
   input  logic                      pop,
   output cbc_pkg::item_type         pop_item,
   output cbc_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cbc_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/cbc_back.sv
// back end: bank registers, address mapping and result register
`timescale 1ns / 1ps
module cbc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [cbc_pkg::KIND_W-1:0]  csr_write_data,
   input  cbc_pkg::queue_status_type   queue_status,
   input  cbc_pkg::item_type           item,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cbc_pkg::rsp_type            rsp_word
);

   logic [cbc_pkg::KIND_W-1:0]     kind_ff;
   logic [cbc_pkg::ROM_BANK_W-1:0] rom_bank_ff, rom_bank_in;
   logic [cbc_pkg::RAM_BANK_W-1:0] ram_bank_ff, ram_bank_in;
   logic                           ram_on_ff, ram_on_in;
   logic                           mode_ff, mode_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   cbc_pkg::rsp_type               rsp_ff, rsp_in;
   cbc_pkg::rsp_type               mapped;
   logic [4:0]                     mbc1_low;
   logic [6:0]                     mbc3_low;
   logic [cbc_pkg::ROM_BANK_W-1:0] rom_sel;

   assign pop       = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // bank number zero is remapped to one
   assign mbc1_low = (item.data[4:0] == 5'd0) ? 5'd1 : item.data[4:0];
   assign mbc3_low = (item.data[6:0] == 7'd0) ? 7'd1 : item.data[6:0];
   assign rom_sel  = item.rom_upper ? rom_bank_ff : '0;

   // address mapping for the word at the head of the queue
   always_comb begin
      mapped = '0;
      unique case (item.op)
         cbc_pkg::FUNC_ROM_READ: begin
            mapped.memory_address = {rom_sel, item.offset};
            mapped.memory_strobe  = 1'b1;
         end
         cbc_pkg::FUNC_REG_WRITE: begin
            mapped = '0;
         end
         cbc_pkg::FUNC_RAM_READ, cbc_pkg::FUNC_RAM_WRITE: begin
            if (ram_on_ff) begin
               mapped.memory_address = cbc_pkg::MEM_ADDR_W'(
                  {ram_bank_ff, item.offset[cbc_pkg::RAM_BANK_BITS-1:0]});
               mapped.memory_strobe  = 1'b1;
               mapped.ram_select     = 1'b1;
               if (item.op == cbc_pkg::FUNC_RAM_WRITE) begin
                  mapped.memory_write = 1'b1;
                  mapped.store_data   = item.data;
               end
            end else if (item.op == cbc_pkg::FUNC_RAM_READ) begin
               mapped.open_bus = 1'b1;
            end
         end
         default: mapped = '0;
      endcase
   end

   // bank register updates
   always_comb begin
      rom_bank_in = rom_bank_ff;
      ram_bank_in = ram_bank_ff;
      ram_on_in   = ram_on_ff;
      mode_in     = mode_ff;
      if (pop && item.op == cbc_pkg::FUNC_REG_WRITE) begin
         if (item.target == cbc_pkg::TGT_RAM_ENABLE && kind_ff != cbc_pkg::KIND_UNUSED) begin
            ram_on_in = (item.data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
         end else begin
            unique case (kind_ff)
               cbc_pkg::KIND_MBC1: begin
                  unique case (item.target)
                     cbc_pkg::TGT_ROM_BANK_LO, cbc_pkg::TGT_ROM_BANK_HI: begin
                        rom_bank_in = {rom_bank_ff[8:5], mbc1_low};
                     end
                     cbc_pkg::TGT_RAM_BANK: begin
                        if (mode_ff) begin
                           ram_bank_in = {2'b00, item.data[1:0]};
                        end else begin
                           rom_bank_in = {2'b00, item.data[1:0], rom_bank_ff[4:0]};
                        end
                     end
                     cbc_pkg::TGT_MODE: begin
                        if (item.data != 8'd0) begin
                           rom_bank_in = {4'd0, rom_bank_ff[4:0]};
                           mode_in     = 1'b1;
                        end else begin
                           ram_bank_in = '0;
                           mode_in     = 1'b0;
                        end
                     end
                     default: ;
                  endcase
               end
               cbc_pkg::KIND_MBC3: begin
                  unique case (item.target)
                     cbc_pkg::TGT_ROM_BANK_LO, cbc_pkg::TGT_ROM_BANK_HI: begin
                        rom_bank_in = {2'b00, mbc3_low};
                     end
                     cbc_pkg::TGT_RAM_BANK: begin
                        // clock register selects leave the ram bank alone
                        if (item.data <= cbc_pkg::MBC3_RAM_BANK_MAX) begin
                           ram_bank_in = item.data[3:0];
                        end
                     end
                     default: ;
                  endcase
               end
               cbc_pkg::KIND_MBC5: begin
                  unique case (item.target)
                     cbc_pkg::TGT_ROM_BANK_LO: rom_bank_in = {rom_bank_ff[8], item.data};
                     cbc_pkg::TGT_ROM_BANK_HI: rom_bank_in = {item.data[0], rom_bank_ff[7:0]};
                     cbc_pkg::TGT_RAM_BANK:    ram_bank_in = item.data[3:0];
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = pop;
         rsp_in       = mapped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= cbc_pkg::KIND_MBC1;
         rom_bank_ff  <= cbc_pkg::ROM_BANK_W'(1);
         ram_bank_ff  <= '0;
         ram_on_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            kind_ff <= csr_write_data;
         end
         rom_bank_ff  <= rom_bank_in;
         ram_bank_ff  <= ram_bank_in;
         ram_on_ff    <= ram_on_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

### hw/rtl/cartridge_bank_controller_unit.sv
// Cartridge bank controller: maps each cartridge bus word (rom read, bank
// register write, ram read or write) to a physical rom or ram byte address
// under MBC1, MBC3 or MBC5 rules picked by the csr register. A new word is
// taken every cycle unless req_stall is set; it passes the front register,
// queue and result register. The sustained rate of one word per cycle while
// rsp is not stalled is set by the back end, which updates the bank registers
// and maps one word per cycle in order. A queue of QUEUE_DEPTH words lets the
// request side keep going while rsp is stalled. Write the csr only while idle.
`timescale 1ns / 1ps
`include "cartridge_bank_controller_unit_macros.svh"
module cartridge_bank_controller_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [cbc_pkg::KIND_W-1:0] csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  cbc_pkg::req_type           req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cbc_pkg::rsp_type           rsp_word
);

   cbc_pkg::queue_status_type queue_status;
   cbc_pkg::item_type         push_item;
   cbc_pkg::item_type         pop_item;
   logic                      push;
   logic                      pop;
   logic                      rsp_write_seen;
   logic                      rsp_ram_access;
   logic                      rsp_open_seen;
   logic                      rsp_no_access;

   cbc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .queue_status (queue_status),
      .push         (push),
      .push_item    (push_item)
   );

   cbc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (queue_status)
   );

   cbc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_status     (queue_status),
      .item             (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word)
   );

   assign rsp_write_seen = rsp_valid && rsp_word.memory_write;
   assign rsp_ram_access = rsp_word.memory_strobe && rsp_word.ram_select;
   assign rsp_open_seen  = rsp_valid && rsp_word.open_bus;
   assign rsp_no_access  = !rsp_word.memory_strobe && !rsp_word.ram_select;

   // queue never pushed when full, never popped when empty
   `CBC_ASSERT_SAME(a_no_overflow, clock, reset, queue_status.full, !push)
   `CBC_ASSERT_SAME(a_no_underflow, clock, reset, queue_status.empty, !pop)
   // a ram write result always targets ram storage
   `CBC_ASSERT_SAME(a_write_is_ram, clock, reset, rsp_write_seen, rsp_ram_access)
   // open bus never comes with a storage access
   `CBC_ASSERT_SAME(a_open_bus_idle, clock, reset, rsp_open_seen, rsp_no_access)

endmodule

### test/cartridge_bank_controller_unit_tb.sv
// self-checking testbench for the cartridge bank controller unit
`timescale 1ns / 1ps
module cartridge_bank_controller_unit_tb;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 150;
   localparam int REPORT_MAX   = 10;

   // register selected by address bits 14..13 of a rom-area write
   localparam logic [1:0] SEL_RAM_ENABLE = 2'd0;
   localparam logic [1:0] SEL_ROM_BANK   = 2'd1;
   localparam logic [1:0] SEL_RAM_BANK   = 2'd2;
   localparam logic [1:0] SEL_MODE       = 2'd3;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [cbc_pkg::KIND_W-1:0] csr_write_data;
   logic                       req_valid;
   logic                       req_stall;
   cbc_pkg::req_type           req_word;
   logic                       rsp_valid;
   logic                       rsp_stall;
   cbc_pkg::rsp_type           rsp_word;

   // bank state as the controller should hold it
   logic [cbc_pkg::KIND_W-1:0]     kind_sel;
   logic [cbc_pkg::ROM_BANK_W-1:0] rom_bank_q;
   logic [cbc_pkg::RAM_BANK_W-1:0] ram_bank_q;
   logic                           ram_enabled;
   logic                           ram_mode;

   cbc_pkg::rsp_type mapped_q[$];
   int      idle_pct;
   int      stall_pct;
   int      hold_len;
   int      hold_left;
   int      cycle_count;
   int      fail_count;
   int      words_sent;
   int      words_checked;
   int      words_per_kind[4];

   cartridge_bank_controller_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, mapped_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [14:0] reg_addr(input logic [1:0] sel, input logic hi,
                                            input logic [11:0] low);
      return {sel, hi, low};
   endfunction

   // applies one access to the bank state and returns the mapped word
   function automatic cbc_pkg::rsp_type map_access(input cbc_pkg::req_type w);
      cbc_pkg::rsp_type r;
      logic [2:0]       region;
      logic [7:0]       v;
      logic [4:0]       lo5;
      logic [6:0]       lo7;
      r      = '0;
      region = w.bus_address[14:12];
      v      = w.write_data;
      lo5    = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
      lo7    = (v[6:0] == 7'd0) ? 7'd1 : v[6:0];
      case (cbc_pkg::func_type'(w.func))
         cbc_pkg::FUNC_ROM_READ: begin
            r.memory_address = {(w.bus_address[14] ? rom_bank_q : 9'd0),
                                w.bus_address[13:0]};
            r.memory_strobe  = 1'b1;
         end
         cbc_pkg::FUNC_REG_WRITE: begin
            if (kind_sel == cbc_pkg::KIND_UNUSED) begin
               // unused kind: register writes have no effect
            end else if (region[2:1] == SEL_RAM_ENABLE) begin
               ram_enabled = (v[3:0] == cbc_pkg::RAM_ENABLE_KEY);
            end else if (kind_sel == cbc_pkg::KIND_MBC1) begin
               case (region[2:1])
                  SEL_ROM_BANK: rom_bank_q = {rom_bank_q[8:5], lo5};
                  SEL_RAM_BANK: begin
                     if (ram_mode)
                        ram_bank_q = {2'b00, v[1:0]};
                     else
                        rom_bank_q = {2'b00, v[1:0], rom_bank_q[4:0]};
                  end
                  default: begin
                     if (v != 8'd0) begin
                        rom_bank_q = {4'd0, rom_bank_q[4:0]};
                        ram_mode   = 1'b1;
                     end else begin
                        ram_bank_q = '0;
                        ram_mode   = 1'b0;
                     end
                  end
               endcase
            end else if (kind_sel == cbc_pkg::KIND_MBC3) begin
               if (region[2:1] == SEL_ROM_BANK)
                  rom_bank_q = {2'b00, lo7};
               else if (region[2:1] == SEL_RAM_BANK && v <= cbc_pkg::MBC3_RAM_BANK_MAX)
                  ram_bank_q = v[3:0];
            end else begin
               if (region[2:1] == SEL_ROM_BANK && !region[0])
                  rom_bank_q[7:0] = v;
               else if (region[2:1] == SEL_ROM_BANK)
                  rom_bank_q[8] = v[0];
               else if (region[2:1] == SEL_RAM_BANK)
                  ram_bank_q = v[3:0];
            end
         end
         default: begin
            if (ram_enabled) begin
               r.memory_address = {6'd0, ram_bank_q, w.bus_address[12:0]};
               r.memory_strobe  = 1'b1;
               r.ram_select     = 1'b1;
               if (cbc_pkg::func_type'(w.func) == cbc_pkg::FUNC_RAM_WRITE) begin
                  r.memory_write = 1'b1;
                  r.store_data   = v;
               end
            end else if (cbc_pkg::func_type'(w.func) == cbc_pkg::FUNC_RAM_READ) begin
               r.open_bus = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   // result side: check each accepted word
   always @(posedge clock) begin
      cbc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (mapped_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("unexpected word: addr %h strobe %b wr %b ram %b open %b data %h",
                        rsp_word.memory_address, rsp_word.memory_strobe,
                        rsp_word.memory_write, rsp_word.ram_select, rsp_word.open_bus,
                        rsp_word.store_data);
         end else begin
            want = mapped_q.pop_front();
            if (rsp_word.memory_address !== want.memory_address ||
                rsp_word.memory_strobe  !== want.memory_strobe  ||
                rsp_word.memory_write   !== want.memory_write   ||
                rsp_word.ram_select     !== want.ram_select     ||
                rsp_word.open_bus       !== want.open_bus       ||
                rsp_word.store_data     !== want.store_data) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("mismatch exp: addr %h strobe %b wr %b ram %b open %b data %h",
                           want.memory_address, want.memory_strobe, want.memory_write,
                           want.ram_select, want.open_bus, want.store_data);
                  $display("         got: addr %h strobe %b wr %b ram %b open %b data %h",
                           rsp_word.memory_address, rsp_word.memory_strobe,
                           rsp_word.memory_write, rsp_word.ram_select,
                           rsp_word.open_bus, rsp_word.store_data);
               end
            end
         end
      end
   end

   // result stall: a long hold when one is requested, otherwise random
   always @(posedge clock) begin
      if (hold_len != 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_word(input cbc_pkg::req_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      mapped_q.push_back(map_access(w));
      words_sent++;
      words_per_kind[kind_sel]++;
   endtask

   task automatic send_access(input cbc_pkg::func_type f, input logic [14:0] a,
                              input logic [7:0] d);
      cbc_pkg::req_type w;
      w.func        = f;
      w.bus_address = a;
      w.write_data  = d;
      send_word(w);
   endtask

   // sender pauses until every expected word has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (mapped_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_kind(input logic [cbc_pkg::KIND_W-1:0] k);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= k;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      kind_sel = k;
   endtask

   function automatic cbc_pkg::req_type random_access();
      cbc_pkg::req_type w;
      int               pick;
      w.bus_address = 15'($urandom);
      w.write_data  = 8'($urandom);
      pick          = $urandom_range(99);
      if (pick < 35) begin
         w.func = cbc_pkg::FUNC_REG_WRITE;
         // bias data toward the values that change behavior
         case (w.bus_address[14:13])
            SEL_RAM_ENABLE:
               if ($urandom_range(9) < 7) w.write_data[3:0] = cbc_pkg::RAM_ENABLE_KEY;
            SEL_ROM_BANK:   if ($urandom_range(3) == 0) w.write_data[6:0] = 7'd0;
            SEL_RAM_BANK:   if ($urandom_range(1) == 0) w.write_data = 8'($urandom_range(7));
            default:        if ($urandom_range(1) == 0) w.write_data = 8'd0;
         endcase
      end else if (pick < 60) begin
         w.func = cbc_pkg::FUNC_ROM_READ;
      end else if (pick < 80) begin
         w.func = cbc_pkg::FUNC_RAM_READ;
      end else begin
         w.func = cbc_pkg::FUNC_RAM_WRITE;
      end
      return w;
   endfunction

   task automatic test_reset_defaults();
      send_access(cbc_pkg::FUNC_ROM_READ, 15'h0000, 8'h00);
      send_access(cbc_pkg::FUNC_ROM_READ, 15'h7FFF, 8'h00);
      send_access(cbc_pkg::FUNC_RAM_READ, 15'h0000, 8'h00);
      send_access(cbc_pkg::FUNC_RAM_WRITE, 15'h1FFF, 8'hFF);
   endtask

   task automatic test_mbc1_rules();
      set_kind(cbc_pkg::KIND_MBC1);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_RAM_ENABLE, 1'b1, 12'hFFF), 8'hFA);
      send_access(cbc_pkg::FUNC_RAM_WRITE, 15'h7FFF, 8'hA5);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_ROM_BANK, 1'b0, 12'h000), 8'h00);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_RAM_BANK, 1'b0, 12'h000), 8'h03);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_ROM_BANK, 1'b1, 12'hFFF), 8'hE0);
      send_access(cbc_pkg::FUNC_ROM_READ, 15'h4000, 8'h00);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_MODE, 1'b0, 12'h000), 8'h01);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_RAM_BANK, 1'b1, 12'hFFF), 8'hFF);
      send_access(cbc_pkg::FUNC_RAM_READ, 15'h0000, 8'h00);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_MODE, 1'b1, 12'hFFF), 8'h00);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_RAM_ENABLE, 1'b0, 12'h000), 8'h0B);
   endtask

   task automatic test_mbc3_rules();
      set_kind(cbc_pkg::KIND_MBC3);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_ROM_BANK, 1'b0, 12'h000), 8'h80);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_ROM_BANK, 1'b0, 12'h000), 8'hFF);
      // clock selects above 7 leave the ram bank alone
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_RAM_BANK, 1'b0, 12'h000), 8'h08);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_RAM_BANK, 1'b0, 12'h000), 8'h07);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_MODE, 1'b0, 12'h000), 8'h55);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_RAM_ENABLE, 1'b0, 12'h000), 8'h0A);
      send_access(cbc_pkg::FUNC_RAM_READ, 15'h1234, 8'h00);
   endtask

   task automatic test_mbc5_rules();
      set_kind(cbc_pkg::KIND_MBC5);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_ROM_BANK, 1'b0, 12'h000), 8'h00);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_ROM_BANK, 1'b1, 12'h000), 8'h01);
      send_access(cbc_pkg::FUNC_ROM_READ, 15'h7FFF, 8'h00);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_RAM_BANK, 1'b0, 12'h000), 8'hFF);
      send_access(cbc_pkg::FUNC_RAM_WRITE, 15'h1FFF, 8'h00);
   endtask

   task automatic test_unused_kind();
      set_kind(cbc_pkg::KIND_UNUSED);
      send_access(cbc_pkg::FUNC_REG_WRITE, reg_addr(SEL_ROM_BANK, 1'b0, 12'h000), 8'h05);
      send_access(cbc_pkg::FUNC_ROM_READ, 15'h4000, 8'h00);
   endtask

   task automatic test_random_traffic();
      int idle_mix[4]  = '{0, 60, 0, 18};
      int stall_mix[4] = '{0, 0, 60, 18};
      int count;
      for (int phase = 0; phase < 4; phase++) begin
         for (int k = 0; k < 4; k++) begin
            set_kind(cbc_pkg::KIND_W'(k));
            idle_pct  = idle_mix[phase];
            stall_pct = stall_mix[phase];
            count     = (k == 3) ? 40 : 130;
            repeat (count) send_word(random_access());
         end
      end
   endtask

   // long result hold while words keep coming: queue fills and req stalls
   task automatic test_backpressure();
      set_kind(cbc_pkg::KIND_MBC1);
      idle_pct  = 0;
      stall_pct = 0;
      hold_len  = HOLD_CYCLES;
      repeat (40) send_word(random_access());
      wait_idle();
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_word         = '0;
      rsp_stall        = 1'b0;
      idle_pct         = 0;
      stall_pct        = 0;
      hold_len         = 0;
      hold_left        = 0;
      cycle_count      = 0;
      fail_count       = 0;
      words_sent       = 0;
      words_checked    = 0;
      words_per_kind   = '{0, 0, 0, 0};
      kind_sel         = cbc_pkg::KIND_MBC1;
      rom_bank_q       = 9'd1;
      ram_bank_q       = '0;
      ram_enabled      = 1'b0;
      ram_mode         = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_mbc1_rules();
      test_mbc3_rules();
      test_mbc5_rules();
      test_unused_kind();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d words sent, %0d checked; mbc1 %0d, mbc3 %0d, mbc5 %0d, unused kind %0d",
               words_sent, words_checked, words_per_kind[0], words_per_kind[1],
               words_per_kind[2], words_per_kind[3]);
      $display("idle/stall mixes 0/0 60/0 0/60 18/18 plus a %0d-cycle result hold",
               HOLD_CYCLES);
      if (fail_count == 0 && mapped_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### cartridge_bank_controller_unit.f
+incdir+hw/rtl
hw/rtl/cbc_pkg.sv
hw/rtl/cbc_front.sv
hw/rtl/cbc_queue.sv
hw/rtl/cbc_back.sv
hw/rtl/cartridge_bank_controller_unit.sv
test/cartridge_bank_controller_unit_tb.sv
